### rtl/mctvf_pkg.sv
package mctvf_pkg;

  // parameter defaults
  localparam int CAM_COUNT_DEF     = 4;
  localparam int HISTORY_DEPTH_DEF = 8;

  // field widths
  localparam int CAM_W  = 2;
  localparam int TIME_W = 40;
  localparam int POS_W  = 16;
  localparam int VEL_W  = 21;
  localparam int AGE_W  = 8;
  localparam int AFF_W  = 8;
  localparam int SPAN_W = 32;

  // time offset from the oldest history entry, signed
  localparam int T_W = TIME_W + 1;

  // fit arithmetic: wide accumulator and multiplier operand widths,
  // sized for the deepest history
  localparam int ACC_W = 96;
  localparam int MB_W  = 48;

  localparam logic [AGE_W-1:0]  AGE_MAX        = 8'd255;
  localparam logic [AGE_W-1:0]  AGE_LOST       = 8'd1;
  localparam logic [AFF_W-1:0]  AFFINITY_RESET = 8'd30;
  localparam logic [SPAN_W-1:0] MAX_SPAN_RESET = 32'd266667;
  localparam logic [MB_W-1:0]   US_PER_S       = 48'd1000000;

  // input kinds
  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_FRAME = 1'b1;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_AFFINITY = 1'b0,
    REG_MAX_SPAN = 1'b1
  } reg_idx_t;

  // multiply and divide steps of the fit
  typedef enum logic [3:0] {
    ST_TT, ST_TX, ST_TY, ST_DA, ST_DB,
    ST_XA, ST_XB, ST_XS, ST_YA, ST_YB, ST_YS
  } step_t;

  typedef enum logic [3:0] {
    C_IDLE, C_CHECK, C_TERM, C_MGO, C_MWAIT, C_DCHK, C_DGO, C_DWAIT, C_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic  store;
    logic  select;
    logic  clear;
    logic  term;
    logic  mul_start;
    logic  div_start;
    logic  load_out;
    step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic present;
    logic fit_ok;
    logic idx_last;
    logic den_pos;
    logic mul_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/multi_camera_track_velocity_fit.sv
// An end-of-frame word runs the fit only when a source is present and the history is
// full within the span limit; otherwise its result is loaded without a fit. Store
// words are taken only while idle. One frame is worked at a time; the shared
// multiplier and the divider work one bit at a time.
// Reset (rst, synchronous, active high) clears camera flags, ages to 255, source,
// history count, configuration to its reset values and the output valid.
module multi_camera_track_velocity_fit #(
  parameter int CAM_COUNT     = mctvf_pkg::CAM_COUNT_DEF,
  parameter int HISTORY_DEPTH = mctvf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,    // camera, capture_time, pos_x, pos_y
  input  logic        s_tuser,    // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,    // source_camera, out_x, out_y, vel_x, vel_y
  output logic [1:0]  m_tuser,    // present, vel_valid
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  mctvf_pkg::dp_cmd_t    cmd;
  mctvf_pkg::dp_status_t status;

  logic                                  out_present, out_vel_valid;
  logic [mctvf_pkg::CAM_W-1:0]           out_camera;
  logic signed [mctvf_pkg::POS_W-1:0]    out_x, out_y;
  logic signed [mctvf_pkg::VEL_W-1:0]    out_vel_x, out_vel_y;

  mctvf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_mode  (s_tuser),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mctvf_dp #(
    .CAM_COUNT     (CAM_COUNT),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .in_camera     (s_tdata[1:0]),
    .in_time       (s_tdata[41:2]),
    .in_x          ($signed(s_tdata[57:42])),
    .in_y          ($signed(s_tdata[73:58])),
    .cfg_we        (cfg_we),
    .cfg_index     (mctvf_pkg::reg_idx_t'(cfg_index)),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_present   (out_present),
    .out_camera    (out_camera),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_vel_x     (out_vel_x),
    .out_vel_y     (out_vel_y),
    .out_vel_valid (out_vel_valid)
  );

  // result word packing
  assign m_tdata = {4'b0, out_vel_y, out_vel_x, out_y, out_x, out_camera};
  assign m_tuser = {out_vel_valid, out_present};

endmodule

### rtl/mctvf_mul.sv
module mctvf_mul #(
  parameter int A_W = mctvf_pkg::ACC_W,
  parameter int B_W = mctvf_pkg::MB_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [A_W-1:0] a,
  input  logic signed [B_W-1:0] b,
  output logic                  busy,
  output logic                  done,
  output logic signed [A_W-1:0] p
);

  localparam int CNT_W = $clog2(B_W);

  logic [CNT_W-1:0]      cnt;
  logic signed [A_W-1:0] areg;
  logic signed [B_W-1:0] breg;
  logic signed [A_W-1:0] acc;
  logic                  last;

  assign last = (cnt == CNT_W'(B_W - 1));
  assign p    = acc;

  // control: one multiplier bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift and add, top bit of b weighs negative
  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      breg <= b;
      acc  <= '0;
    end else if (busy) begin
      if (breg[0]) begin
        acc <= last ? acc - areg : acc + areg;
      end
      areg <= areg <<< 1;
      breg <= breg >>> 1;
    end
  end

endmodule

### rtl/mctvf_div.sv
module mctvf_div #(
  parameter int W = mctvf_pkg::ACC_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] q
);

  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     nreg;
  logic [W-1:0]     rem;
  logic [W:0]       rem_s;
  logic             ge;

  assign rem_s = {rem, nreg[W-1]};
  assign ge    = (rem_s >= {1'b0, den});

  // control: one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division
  always_ff @(posedge clk) begin
    if (start) begin
      nreg <= num;
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      nreg <= nreg << 1;
      rem  <= ge ? W'(rem_s - {1'b0, den}) : W'(rem_s);
      q    <= {q[W-2:0], ge};
    end
  end

endmodule

### rtl/mctvf_ctrl.sv
module mctvf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_mode,
  output logic                   in_ready,
  input  mctvf_pkg::dp_status_t  status,
  output mctvf_pkg::dp_cmd_t     cmd
);

  mctvf_pkg::ctrl_state_t state, state_next;
  mctvf_pkg::step_t       step, step_next;

  // state and step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mctvf_pkg::C_IDLE;
      step  <= mctvf_pkg::ST_TT;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // sequencing of one frame
  always_comb begin
    state_next    = state;
    step_next     = step;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step      = step;
    unique case (state)
      mctvf_pkg::C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == mctvf_pkg::MODE_STORE) begin
            cmd.store = 1'b1;
          end else begin
            cmd.select = 1'b1;
            state_next = mctvf_pkg::C_CHECK;
          end
        end
      end
      mctvf_pkg::C_CHECK: begin
        if (status.present && status.fit_ok) begin
          cmd.clear  = 1'b1;
          step_next  = mctvf_pkg::ST_TT;
          state_next = mctvf_pkg::C_TERM;
        end else begin
          state_next = mctvf_pkg::C_OUT;
        end
      end
      mctvf_pkg::C_TERM: begin
        cmd.term   = 1'b1;
        step_next  = mctvf_pkg::ST_TT;
        state_next = mctvf_pkg::C_MGO;
      end
      mctvf_pkg::C_MGO: begin
        cmd.mul_start = 1'b1;
        state_next    = mctvf_pkg::C_MWAIT;
      end
      mctvf_pkg::C_MWAIT: begin
        if (status.mul_done) begin
          state_next = mctvf_pkg::C_MGO;
          unique case (step)
            mctvf_pkg::ST_TT: step_next = mctvf_pkg::ST_TX;
            mctvf_pkg::ST_TX: step_next = mctvf_pkg::ST_TY;
            mctvf_pkg::ST_TY: begin
              if (status.idx_last) begin
                step_next = mctvf_pkg::ST_DA;
              end else begin
                state_next = mctvf_pkg::C_TERM;
              end
            end
            mctvf_pkg::ST_DA: step_next  = mctvf_pkg::ST_DB;
            mctvf_pkg::ST_DB: state_next = mctvf_pkg::C_DCHK;
            mctvf_pkg::ST_XA: step_next  = mctvf_pkg::ST_XB;
            mctvf_pkg::ST_XB: step_next  = mctvf_pkg::ST_XS;
            mctvf_pkg::ST_XS: state_next = mctvf_pkg::C_DGO;
            mctvf_pkg::ST_YA: step_next  = mctvf_pkg::ST_YB;
            mctvf_pkg::ST_YB: step_next  = mctvf_pkg::ST_YS;
            mctvf_pkg::ST_YS: state_next = mctvf_pkg::C_DGO;
            default:          state_next = mctvf_pkg::C_OUT;
          endcase
        end
      end
      mctvf_pkg::C_DCHK: begin
        if (status.den_pos) begin
          step_next  = mctvf_pkg::ST_XA;
          state_next = mctvf_pkg::C_MGO;
        end else begin
          state_next = mctvf_pkg::C_OUT;
        end
      end
      mctvf_pkg::C_DGO: begin
        cmd.div_start = 1'b1;
        state_next    = mctvf_pkg::C_DWAIT;
      end
      mctvf_pkg::C_DWAIT: begin
        if (status.div_done) begin
          if (step == mctvf_pkg::ST_XS) begin
            step_next  = mctvf_pkg::ST_YA;
            state_next = mctvf_pkg::C_MGO;
          end else begin
            state_next = mctvf_pkg::C_OUT;
          end
        end
      end
      mctvf_pkg::C_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = mctvf_pkg::C_IDLE;
        end
      end
      default: state_next = mctvf_pkg::C_IDLE;
    endcase
  end

endmodule

### rtl/mctvf_dp.sv
module mctvf_dp #(
  parameter int CAM_COUNT     = mctvf_pkg::CAM_COUNT_DEF,
  parameter int HISTORY_DEPTH = mctvf_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  mctvf_pkg::dp_cmd_t                     cmd,
  output mctvf_pkg::dp_status_t                  status,
  input  logic [mctvf_pkg::CAM_W-1:0]            in_camera,
  input  logic [mctvf_pkg::TIME_W-1:0]           in_time,
  input  logic signed [mctvf_pkg::POS_W-1:0]     in_x,
  input  logic signed [mctvf_pkg::POS_W-1:0]     in_y,
  input  logic                                   cfg_we,
  input  mctvf_pkg::reg_idx_t                    cfg_index,
  input  logic [mctvf_pkg::SPAN_W-1:0]           cfg_wdata,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_present,
  output logic [mctvf_pkg::CAM_W-1:0]            out_camera,
  output logic signed [mctvf_pkg::POS_W-1:0]     out_x,
  output logic signed [mctvf_pkg::POS_W-1:0]     out_y,
  output logic signed [mctvf_pkg::VEL_W-1:0]     out_vel_x,
  output logic signed [mctvf_pkg::VEL_W-1:0]     out_vel_y,
  output logic                                   out_vel_valid
);

  localparam int CAM_IW  = (CAM_COUNT > 1) ? $clog2(CAM_COUNT) : 1;
  localparam int HIST_IW = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int LOG_N   = $clog2(HISTORY_DEPTH);
  localparam int ST_W    = mctvf_pkg::T_W + LOG_N;
  localparam int SP_W    = mctvf_pkg::POS_W + LOG_N;
  localparam int TW      = mctvf_pkg::TIME_W;
  localparam int PW      = mctvf_pkg::POS_W;
  localparam int VW      = mctvf_pkg::VEL_W;
  localparam int AW      = mctvf_pkg::ACC_W;
  localparam int BW      = mctvf_pkg::MB_W;
  localparam logic [AW-1:0] VEL_MAG_NEG = AW'(2 ** (VW - 1));
  localparam logic [AW-1:0] VEL_MAG_POS = AW'(2 ** (VW - 1) - 1);

  // configuration
  logic [mctvf_pkg::AFF_W-1:0]  affinity;
  logic [mctvf_pkg::SPAN_W-1:0] max_span;

  // camera observations
  logic                          cam_valid [CAM_COUNT];
  logic [mctvf_pkg::AGE_W-1:0]   cam_age   [CAM_COUNT];
  logic [TW-1:0]                 cam_time  [CAM_COUNT];
  logic signed [PW-1:0]          cam_x     [CAM_COUNT];
  logic signed [PW-1:0]          cam_y     [CAM_COUNT];
  logic                          src_have;
  logic [CAM_IW-1:0]             src_sel;

  // history line
  logic [TW-1:0]        ht [HISTORY_DEPTH];
  logic signed [PW-1:0] hx [HISTORY_DEPTH];
  logic signed [PW-1:0] hy [HISTORY_DEPTH];
  logic [CNT_W-1:0]     hist_count;
  logic [HIST_IW-1:0]   idx;

  // fit registers
  logic signed [mctvf_pkg::T_W-1:0] tcur, tcur_next;
  logic signed [ST_W-1:0]           st;
  logic signed [SP_W-1:0]           spx, spy;
  logic signed [AW-1:0]             stt, stpx, stpy, tmp, den, num;
  logic signed [VW-1:0]             vel_x, vel_y;
  logic                             vel_valid;

  // pending result fields
  logic                 pend_present;
  logic [CAM_IW-1:0]    pend_cam;
  logic signed [PW-1:0] pend_x, pend_y;

  // source selection
  logic              found, keep, new_have;
  logic [CAM_IW-1:0] first, new_sel;
  logic              cam_ok;
  logic [CAM_IW-1:0] cam_idx;

  assign cam_idx = CAM_IW'(in_camera);
  assign cam_ok  = (32'(in_camera) < CAM_COUNT);

  always_comb begin
    found = 1'b0;
    first = '0;
    for (int i = CAM_COUNT - 1; i >= 0; i--) begin
      if (cam_valid[i]) begin
        found = 1'b1;
        first = CAM_IW'(i);
      end
    end
  end

  assign keep = src_have && cam_valid[src_sel];

  always_comb begin
    new_have = 1'b0;
    new_sel  = src_sel;
    priority if (keep) begin
      new_have = 1'b1;
    end else if (found) begin
      new_have = 1'b1;
      new_sel  = first;
    end else if (src_have && (cam_age[src_sel] < affinity)) begin
      new_have = 1'b1;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      affinity <= mctvf_pkg::AFFINITY_RESET;
      max_span <= mctvf_pkg::MAX_SPAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mctvf_pkg::REG_AFFINITY: affinity <= cfg_wdata[mctvf_pkg::AFF_W-1:0];
        mctvf_pkg::REG_MAX_SPAN: max_span <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // camera valid flags, ages and source
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAM_COUNT; i++) begin
        cam_valid[i] <= 1'b0;
        cam_age[i]   <= mctvf_pkg::AGE_MAX;
      end
      src_have <= 1'b0;
      src_sel  <= '0;
    end else if (cmd.store) begin
      if (cam_ok) begin
        cam_valid[cam_idx] <= 1'b1;
      end
    end else if (cmd.select) begin
      src_have <= new_have;
      src_sel  <= new_sel;
      for (int i = 0; i < CAM_COUNT; i++) begin
        if (cam_valid[i]) begin
          cam_valid[i] <= 1'b0;
          cam_age[i]   <= mctvf_pkg::AGE_LOST;
        end else if (cam_age[i] != mctvf_pkg::AGE_MAX) begin
          cam_age[i] <= cam_age[i] + 1'b1;
        end
      end
    end
  end

  // camera observation payload
  always_ff @(posedge clk) begin
    if (cmd.store && cam_ok) begin
      cam_time[cam_idx] <= in_time;
      cam_x[cam_idx]    <= in_x;
      cam_y[cam_idx]    <= in_y;
    end
  end

  // history count
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_count <= '0;
    end else if (cmd.select && new_have && (hist_count != CNT_W'(HISTORY_DEPTH))) begin
      hist_count <= hist_count + 1'b1;
    end
  end

  // history push: shift when full, otherwise write at the fill point
  always_ff @(posedge clk) begin
    if (cmd.select && new_have) begin
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        if (hist_count == CNT_W'(HISTORY_DEPTH)) begin
          if (j == HISTORY_DEPTH - 1) begin
            ht[j] <= cam_time[new_sel];
            hx[j] <= cam_x[new_sel];
            hy[j] <= cam_y[new_sel];
          end else begin
            ht[j] <= ht[j+1];
            hx[j] <= hx[j+1];
            hy[j] <= hy[j+1];
          end
        end else if (hist_count == CNT_W'(j)) begin
          ht[j] <= cam_time[new_sel];
          hx[j] <= cam_x[new_sel];
          hy[j] <= cam_y[new_sel];
        end
      end
    end
  end

  // pending output fields
  always_ff @(posedge clk) begin
    if (cmd.select) begin
      pend_present <= new_have;
      pend_cam     <= new_have ? new_sel : '0;
      pend_x       <= new_have ? cam_x[new_sel] : '0;
      pend_y       <= new_have ? cam_y[new_sel] : '0;
    end
  end

  // span check over the full history
  logic signed [mctvf_pkg::T_W-1:0] span;
  assign span = $signed({1'b0, ht[HISTORY_DEPTH-1]}) - $signed({1'b0, ht[0]});
  assign tcur_next = $signed({1'b0, ht[idx]}) - $signed({1'b0, ht[0]});

  // shared multiplier operands
  logic signed [AW-1:0] mul_a, mul_p;
  logic signed [BW-1:0] mul_b;
  logic                 mul_busy, mul_done;

  always_comb begin
    mul_a = AW'(tcur);
    mul_b = BW'(tcur);
    unique case (cmd.step)
      mctvf_pkg::ST_TT: begin mul_a = AW'(tcur); mul_b = BW'(tcur);    end
      mctvf_pkg::ST_TX: begin mul_a = AW'(tcur); mul_b = BW'(hx[idx]); end
      mctvf_pkg::ST_TY: begin mul_a = AW'(tcur); mul_b = BW'(hy[idx]); end
      mctvf_pkg::ST_DA: begin mul_a = stt;  mul_b = BW'(HISTORY_DEPTH);  end
      mctvf_pkg::ST_DB: begin mul_a = AW'(st); mul_b = BW'(st);        end
      mctvf_pkg::ST_XA: begin mul_a = stpx; mul_b = BW'(HISTORY_DEPTH);  end
      mctvf_pkg::ST_XB: begin mul_a = AW'(st); mul_b = BW'(spx);       end
      mctvf_pkg::ST_XS: begin mul_a = num;  mul_b = mctvf_pkg::US_PER_S; end
      mctvf_pkg::ST_YA: begin mul_a = stpy; mul_b = BW'(HISTORY_DEPTH);  end
      mctvf_pkg::ST_YB: begin mul_a = AW'(st); mul_b = BW'(spy);       end
      mctvf_pkg::ST_YS: begin mul_a = num;  mul_b = mctvf_pkg::US_PER_S; end
      default: ;
    endcase
  end

  mctvf_mul #(.A_W(AW), .B_W(BW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  // divider on the numerator magnitude
  logic            num_neg;
  logic [AW-1:0]   num_mag, q;
  logic            div_done;
  logic signed [VW-1:0] vel_sat;

  assign num_neg = num[AW-1];
  assign num_mag = num_neg ? AW'(-num) : AW'(num);

  mctvf_div #(.W(AW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num_mag),
    .den   (den),
    .done  (div_done),
    .q     (q)
  );

  // truncate and saturate the quotient
  always_comb begin
    if (num_neg) begin
      vel_sat = (q >= VEL_MAG_NEG) ? {1'b1, {(VW-1){1'b0}}} : -$signed(VW'(q));
    end else begin
      vel_sat = (q > VEL_MAG_POS) ? {1'b0, {(VW-1){1'b1}}} : $signed(VW'(q));
    end
  end

  // fit accumulation
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      st   <= '0;
      spx  <= '0;
      spy  <= '0;
      stt  <= '0;
      stpx <= '0;
      stpy <= '0;
      idx  <= '0;
    end else if (cmd.term) begin
      tcur <= tcur_next;
      st   <= st + ST_W'(tcur_next);
      spx  <= spx + SP_W'(hx[idx]);
      spy  <= spy + SP_W'(hy[idx]);
    end else if (mul_done) begin
      unique case (cmd.step)
        mctvf_pkg::ST_TT: stt  <= stt + mul_p;
        mctvf_pkg::ST_TX: stpx <= stpx + mul_p;
        mctvf_pkg::ST_TY: begin
          stpy <= stpy + mul_p;
          idx  <= idx + 1'b1;
        end
        mctvf_pkg::ST_DA: tmp <= mul_p;
        mctvf_pkg::ST_DB: den <= tmp - mul_p;
        mctvf_pkg::ST_XA: tmp <= mul_p;
        mctvf_pkg::ST_XB: num <= tmp - mul_p;
        mctvf_pkg::ST_XS: num <= mul_p;
        mctvf_pkg::ST_YA: tmp <= mul_p;
        mctvf_pkg::ST_YB: num <= tmp - mul_p;
        mctvf_pkg::ST_YS: num <= mul_p;
        default: ;
      endcase
    end
  end

  // velocity results
  always_ff @(posedge clk) begin
    if (rst) begin
      vel_valid <= 1'b0;
    end else if (cmd.select) begin
      vel_valid <= 1'b0;
    end else if (div_done && (cmd.step == mctvf_pkg::ST_YS)) begin
      vel_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      vel_x <= '0;
      vel_y <= '0;
    end else if (div_done) begin
      if (cmd.step == mctvf_pkg::ST_XS) begin
        vel_x <= vel_sat;
      end else begin
        vel_y <= vel_sat;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_present   <= pend_present;
      out_camera    <= mctvf_pkg::CAM_W'(pend_cam);
      out_x         <= pend_x;
      out_y         <= pend_y;
      out_vel_x     <= vel_x;
      out_vel_y     <= vel_y;
      out_vel_valid <= vel_valid;
    end
  end

  // status to the controller
  always_comb begin
    status          = '0;
    status.present  = pend_present;
    status.fit_ok   = (hist_count == CNT_W'(HISTORY_DEPTH)) &&
                      (span <= $signed({{(mctvf_pkg::T_W-mctvf_pkg::SPAN_W){1'b0}}, max_span}));
    status.idx_last = (idx == HIST_IW'(HISTORY_DEPTH - 1));
    status.den_pos  = !den[AW-1] && (den != '0);
    status.mul_done = mul_done;
    status.div_done = div_done;
    status.out_free = !out_valid || out_ready;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hist_count <= CNT_W'(HISTORY_DEPTH))
    else $error("history count beyond depth");

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !mul_busy)
    else $error("multiply started while busy");

  a_vel_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_vel_valid |-> out_present)
    else $error("velocity without a source");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || out_ready)
    else $error("result word overwritten");

endmodule
